FILE: rtl/elrf_pkg.sv
// Package: shared types and constants of the ethernet link recovery machine.
package elrf_pkg;

    // Recovery modes
    localparam logic [2:0] M_NORMAL  = 3'd0;
    localparam logic [2:0] M_PENDING = 3'd1;
    localparam logic [2:0] M_SOFT    = 3'd2;
    localparam logic [2:0] M_HARD    = 3'd3;
    localparam logic [2:0] M_FULL    = 3'd4;

    // Result codes
    localparam logic [1:0] RC_IDLE     = 2'd0;
    localparam logic [1:0] RC_RESTORED = 2'd1;
    localparam logic [1:0] RC_REINIT   = 2'd2;

    // Link flag writes
    localparam logic [1:0] LF_LEAVE = 2'd0;
    localparam logic [1:0] LF_CLEAR = 2'd1;
    localparam logic [1:0] LF_SET   = 2'd2;

    // PHY status codes
    localparam logic [1:0] PHY_DOWN = 2'd0;
    localparam logic [1:0] PHY_UP   = 2'd1;

    // Register indexes
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_POLL       = 3'd1;
    localparam logic [2:0] REG_DOWN_DEB   = 3'd2;
    localparam logic [2:0] REG_ERR_DEB    = 3'd3;
    localparam logic [2:0] REG_SOFT_WAIT  = 3'd4;
    localparam logic [2:0] REG_HARD_WAIT  = 3'd5;

    // Register reset values
    localparam logic [15:0] POLL_RST      = 16'd250;
    localparam logic [15:0] DOWN_DEB_RST  = 16'd1500;
    localparam logic [15:0] ERR_DEB_RST   = 16'd500;
    localparam logic [15:0] SOFT_WAIT_RST = 16'd4000;
    localparam logic [15:0] HARD_WAIT_RST = 16'd5000;

    typedef struct packed {
        logic        enable;
        logic [15:0] poll_interval_ms;
        logic [15:0] down_debounce_ms;
        logic [15:0] error_debounce_ms;
        logic [15:0] soft_wait_ms;
        logic [15:0] hard_wait_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] result_code;
        logic       polled;
        logic [1:0] link_flag_write;
        logic       soft_reset_cmd;
        logic       hard_reset_cmd;
        logic       reinit_cmd;
        logic       announce_up;
        logic [2:0] mode_out;
    } res_t;

endpackage

FILE: rtl/elrf_eval.sv
// Combinational evaluation of one poll tick against the recovery state.
module elrf_eval
    import elrf_pkg::*;
#(
    parameter int TIME_BITS = 32
)(
    input  cfg_t                 cfg,
    input  logic [2:0]           mode,
    input  logic                 was_down,
    input  logic [TIME_BITS-1:0] phase_start,
    input  logic [TIME_BITS-1:0] last_poll,
    input  logic [TIME_BITS-1:0] now,
    input  logic                 ready,
    input  logic [1:0]           phy,
    input  logic                 soft_ok,
    input  logic                 reinit_ok,
    output res_t                 res,
    output logic [2:0]           mode_next,
    output logic                 was_down_next,
    output logic [TIME_BITS-1:0] phase_start_next,
    output logic [TIME_BITS-1:0] last_poll_next
);

    logic [TIME_BITS-1:0] since_poll;
    logic [TIME_BITS-1:0] since_phase;
    logic                 up;
    logic                 err;
    logic                 eval;
    logic [15:0]          debounce;

    // wrapping subtraction, modulo 2^TIME_BITS
    assign since_poll  = now - last_poll;
    assign since_phase = now - phase_start;
    assign up          = (phy == PHY_UP);
    assign err         = (phy != PHY_UP) && (phy != PHY_DOWN);
    assign debounce    = err ? cfg.error_debounce_ms : cfg.down_debounce_ms;
    assign eval        = cfg.enable && ready &&
                         (since_poll >= TIME_BITS'(cfg.poll_interval_ms));

    always_comb
    begin
        res              = '0;
        mode_next        = mode;
        was_down_next    = was_down;
        phase_start_next = phase_start;
        last_poll_next   = last_poll;

        if (eval)
        begin
            last_poll_next = now;
            res.polled     = 1'b1;
            if (!up)
            begin
                res.link_flag_write = LF_CLEAR;
            end

            unique case (mode)
                M_PENDING:
                begin
                    if (up)
                    begin
                        mode_next = M_NORMAL;
                        if (was_down)
                        begin
                            was_down_next   = 1'b0;
                            res.announce_up = 1'b1;
                            res.result_code = RC_RESTORED;
                        end
                    end
                    else if (since_phase >= TIME_BITS'(debounce))
                    begin
                        res.soft_reset_cmd = 1'b1;
                        if (soft_ok)
                        begin
                            mode_next        = M_SOFT;
                            phase_start_next = now;
                        end
                    end
                end
                M_SOFT, M_HARD, M_FULL:
                begin
                    if (up)
                    begin
                        mode_next           = M_NORMAL;
                        was_down_next       = 1'b0;
                        res.link_flag_write = LF_SET;
                        res.announce_up     = 1'b1;
                        res.result_code     = RC_RESTORED;
                    end
                    else if (mode == M_SOFT)
                    begin
                        if (since_phase >= TIME_BITS'(cfg.soft_wait_ms))
                        begin
                            res.hard_reset_cmd = 1'b1;
                            mode_next          = M_HARD;
                            phase_start_next   = now;
                        end
                    end
                    else if (since_phase >= TIME_BITS'(cfg.hard_wait_ms))
                    begin
                        if (mode == M_HARD)
                        begin
                            res.reinit_cmd = 1'b1;
                            if (reinit_ok)
                            begin
                                mode_next       = M_FULL;
                                res.result_code = RC_REINIT;
                            end
                            else
                            begin
                                mode_next = M_PENDING;
                            end
                        end
                        else
                        begin
                            mode_next = M_PENDING;
                        end
                        phase_start_next = now;
                    end
                end
                default:
                begin
                    // normal, and unused codes treated as normal
                    mode_next = M_NORMAL;
                    if (!up)
                    begin
                        mode_next        = M_PENDING;
                        phase_start_next = now;
                        was_down_next    = 1'b1;
                    end
                end
            endcase
        end

        res.mode_out = mode_next;
    end

endmodule

FILE: rtl/ethernet_link_recovery_fsm.sv
// Top level: ethernet link recovery state machine with poll gate and escalation.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | to block  | in_valid / in_stall    | now_ms, netif_ready, phy_status,
//          |           |                        | soft_reset_ok, reinit_ok
//  out     | from block| out_valid / out_stall  | result_code, polled, link_flag_write,
//          |           |                        | soft/hard_reset_cmd, reinit_cmd,
//          |           |                        | announce_up, mode_out
//  cfg     | to block  | cfg_we                 | cfg_index, cfg_data
//
// A tick sits in the input register, then moves to the result register and transfers
// out from there; one tick is taken every cycle while out_stall is low. The tick is
// evaluated by short logic (a few subtracts and compares), and the result plus new
// state land together.
// Reset puts the machine in normal mode with both timestamps at zero and loads
// the register defaults. A stalled output holds its result and backs up the
// input register; in_stall rises only when both are full and out_stall is high.
module ethernet_link_recovery_fsm
    import elrf_pkg::*;
#(
    parameter int TIME_BITS = 32
)(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic        netif_ready,
    input  logic [1:0]  phy_status,
    input  logic        soft_reset_ok,
    input  logic        reinit_ok,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_code,
    output logic        polled,
    output logic [1:0]  link_flag_write,
    output logic        soft_reset_cmd,
    output logic        hard_reset_cmd,
    output logic        reinit_cmd,
    output logic        announce_up,
    output logic [2:0]  mode_out
);

    // configuration registers
    cfg_t cfg_reg;

    // recovery state
    logic [2:0]           mode_reg;
    logic                 was_down_reg;
    logic [TIME_BITS-1:0] phase_start_reg;
    logic [TIME_BITS-1:0] last_poll_reg;

    logic [2:0]           mode_next;
    logic                 was_down_next;
    logic [TIME_BITS-1:0] phase_start_next;
    logic [TIME_BITS-1:0] last_poll_next;

    // input register
    logic        item_valid_reg;
    logic [31:0] item_now_reg;
    logic        item_ready_reg;
    logic [1:0]  item_phy_reg;
    logic        item_soft_ok_reg;
    logic        item_reinit_ok_reg;

    // result register
    logic out_valid_reg;
    res_t res_reg;
    res_t res_next;

    logic                 in_xfer;
    logic                 advance;
    logic [TIME_BITS-1:0] now_w;

    // the tick moves into the result register when that register is empty or being read out
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;
    assign now_w    = TIME_BITS'(item_now_reg);

    elrf_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .cfg              (cfg_reg),
        .mode             (mode_reg),
        .was_down         (was_down_reg),
        .phase_start      (phase_start_reg),
        .last_poll        (last_poll_reg),
        .now              (now_w),
        .ready            (item_ready_reg),
        .phy              (item_phy_reg),
        .soft_ok          (item_soft_ok_reg),
        .reinit_ok        (item_reinit_ok_reg),
        .res              (res_next),
        .mode_next        (mode_next),
        .was_down_next    (was_down_next),
        .phase_start_next (phase_start_next),
        .last_poll_next   (last_poll_next)
    );

    // configuration writes; an enable write also drops back to normal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.poll_interval_ms  <= POLL_RST;
            cfg_reg.down_debounce_ms  <= DOWN_DEB_RST;
            cfg_reg.error_debounce_ms <= ERR_DEB_RST;
            cfg_reg.soft_wait_ms      <= SOFT_WAIT_RST;
            cfg_reg.hard_wait_ms      <= HARD_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:    cfg_reg.enable            <= cfg_data[0];
                REG_POLL:      cfg_reg.poll_interval_ms  <= cfg_data;
                REG_DOWN_DEB:  cfg_reg.down_debounce_ms  <= cfg_data;
                REG_ERR_DEB:   cfg_reg.error_debounce_ms <= cfg_data;
                REG_SOFT_WAIT: cfg_reg.soft_wait_ms      <= cfg_data;
                REG_HARD_WAIT: cfg_reg.hard_wait_ms      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // recovery state; config writes must happen only while idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_NORMAL;
            was_down_reg    <= 1'b0;
            phase_start_reg <= '0;
            last_poll_reg   <= '0;
        end
        else if (cfg_we && (cfg_index == REG_ENABLE))
        begin
            mode_reg        <= M_NORMAL;
            was_down_reg    <= 1'b0;
            phase_start_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            was_down_reg    <= was_down_next;
            phase_start_reg <= phase_start_next;
            last_poll_reg   <= last_poll_next;
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_now_reg       <= now_ms;
            item_ready_reg     <= netif_ready;
            item_phy_reg       <= phy_status;
            item_soft_ok_reg   <= soft_reset_ok;
            item_reinit_ok_reg <= reinit_ok;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_code     = res_reg.result_code;
    assign polled          = res_reg.polled;
    assign link_flag_write = res_reg.link_flag_write;
    assign soft_reset_cmd  = res_reg.soft_reset_cmd;
    assign hard_reset_cmd  = res_reg.hard_reset_cmd;
    assign reinit_cmd      = res_reg.reinit_cmd;
    assign announce_up     = res_reg.announce_up;
    assign mode_out        = res_reg.mode_out;

    // an unpolled tick commands nothing
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !polled) |-> (result_code == RC_IDLE) && !soft_reset_cmd &&
            !hard_reset_cmd && !reinit_cmd && !announce_up &&
            (link_flag_write == LF_LEAVE))
        else $error("idle tick produced a command");

    // announce always goes with a restored code
    a_announce_rc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && announce_up) |-> (result_code == RC_RESTORED))
        else $error("announce without restored code");

    // hard reset always lands in hard-wait
    a_hard_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hard_reset_cmd) |-> (mode_out == M_HARD))
        else $error("hard reset without hard-wait mode");

    // a tick that fails the poll gate leaves the state alone
    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !res_next.polled && !cfg_we) |=>
            ($stable(mode_reg) && $stable(last_poll_reg) &&
             $stable(phase_start_reg) && $stable(was_down_reg)))
        else $error("state changed on unpolled tick");

    // the shown mode matches the state the result was computed into
    a_mode_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (mode_out == mode_reg))
        else $error("mode_out disagrees with state");

endmodule

FILE: test/tb_ethernet_link_recovery_fsm.sv
// Testbench for the ethernet link recovery state machine: predicted results checked per transfer.
`timescale 1ns / 100ps

module tb_ethernet_link_recovery_fsm;
    import elrf_pkg::*;

    // PHY codes the package leaves out: a read error, and the unused code
    // that the block must treat as a read error too.
    localparam logic [1:0] PHY_ERR = 2'd2;
    localparam logic [1:0] PHY_ODD = 2'd3;

    // Long receiver hold, in cycles, used to back the block up into in_stall.
    localparam int LONG_HOLD = 40;
    // Hard limit on the run; far above the slowest correct run.
    localparam int LIMIT_NS = 2_000_000;

    // One poll tick as the sender presents it.
    typedef struct packed {
        logic [31:0] now_ms;
        logic        ready;
        logic [1:0]  phy;
        logic        soft_ok;
        logic        reinit_ok;
    } tick_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] now_ms;
    logic        netif_ready;
    logic [1:0]  phy_status;
    logic        soft_reset_ok;
    logic        reinit_ok;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_code;
    logic        polled;
    logic [1:0]  link_flag_write;
    logic        soft_reset_cmd;
    logic        hard_reset_cmd;
    logic        reinit_cmd;
    logic        announce_up;
    logic [2:0]  mode_out;

    ethernet_link_recovery_fsm uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .now_ms          (now_ms),
        .netif_ready     (netif_ready),
        .phy_status      (phy_status),
        .soft_reset_ok   (soft_reset_ok),
        .reinit_ok       (reinit_ok),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_code     (result_code),
        .polled          (polled),
        .link_flag_write (link_flag_write),
        .soft_reset_cmd  (soft_reset_cmd),
        .hard_reset_cmd  (hard_reset_cmd),
        .reinit_cmd      (reinit_cmd),
        .announce_up     (announce_up),
        .mode_out        (mode_out)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and machine state.
    // ------------------------------------------------------------------
    logic        cfg_on;
    logic [15:0] cfg_poll;
    logic [15:0] cfg_down_deb;
    logic [15:0] cfg_err_deb;
    logic [15:0] cfg_soft_wait;
    logic [15:0] cfg_hard_wait;
    logic [2:0]  rec_mode;
    logic [31:0] phase_t0;
    logic [31:0] last_eval;
    logic        down_seen;

    // Results predicted for accepted ticks, oldest first.
    res_t        expected_results[$];

    // Traffic controls shared with the idling processes.
    bit          idle_on;
    int          hold_req;
    logic [31:0] clock_ms;

    // Run bookkeeping.
    int          fail_count;
    int          results_checked;
    int          polls_seen;
    int          restores_seen;
    int          reinits_seen;
    int          hard_resets_seen;

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    initial
    begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: one tick in, one result out, state updated in place.
    // Elapsed times are plain 32-bit subtractions, so they wrap as the
    // block's timestamps do.
    // ------------------------------------------------------------------
    function automatic res_t link_recovery_step(input tick_t t);
        res_t        r;
        logic        link_up;
        logic        read_err;
        logic [31:0] since_poll;
        logic [31:0] since_phase;
        logic [15:0] debounce;
        r = '0;
        since_poll = t.now_ms - last_eval;
        if (cfg_on && t.ready && since_poll >= 32'(cfg_poll))
        begin
            last_eval = t.now_ms;
            r.polled = 1'b1;
            link_up = (t.phy == PHY_UP);
            // Both the read-error code and the unused code shorten the debounce.
            read_err = t.phy[1];
            since_phase = t.now_ms - phase_t0;
            if (!link_up)
                r.link_flag_write = LF_CLEAR;

            case (rec_mode)
                M_PENDING:
                begin
                    if (link_up)
                    begin
                        // Bounce back from debounce: flag is left alone.
                        rec_mode = M_NORMAL;
                        if (down_seen)
                        begin
                            down_seen = 1'b0;
                            r.announce_up = 1'b1;
                            r.result_code = RC_RESTORED;
                        end
                    end
                    else
                    begin
                        debounce = read_err ? cfg_err_deb : cfg_down_deb;
                        if (since_phase >= 32'(debounce))
                        begin
                            r.soft_reset_cmd = 1'b1;
                            // A failed soft reset keeps us pending for a retry.
                            if (t.soft_ok)
                            begin
                                rec_mode = M_SOFT;
                                phase_t0 = t.now_ms;
                            end
                        end
                    end
                end
                M_SOFT, M_HARD, M_FULL:
                begin
                    if (link_up)
                    begin
                        rec_mode = M_NORMAL;
                        down_seen = 1'b0;
                        r.link_flag_write = LF_SET;
                        r.announce_up = 1'b1;
                        r.result_code = RC_RESTORED;
                    end
                    else if (rec_mode == M_SOFT)
                    begin
                        if (since_phase >= 32'(cfg_soft_wait))
                        begin
                            r.hard_reset_cmd = 1'b1;
                            rec_mode = M_HARD;
                            phase_t0 = t.now_ms;
                        end
                    end
                    else if (since_phase >= 32'(cfg_hard_wait))
                    begin
                        if (rec_mode == M_HARD)
                        begin
                            r.reinit_cmd = 1'b1;
                            if (t.reinit_ok)
                            begin
                                rec_mode = M_FULL;
                                r.result_code = RC_REINIT;
                            end
                            else
                                rec_mode = M_PENDING;
                        end
                        else
                            rec_mode = M_PENDING;
                        phase_t0 = t.now_ms;
                    end
                end
                default:
                begin
                    rec_mode = M_NORMAL;
                    if (!link_up)
                    begin
                        rec_mode = M_PENDING;
                        phase_t0 = t.now_ms;
                        down_seen = 1'b1;
                    end
                end
            endcase
        end
        r.mode_out = rec_mode;
        return r;
    endfunction

    function automatic tick_t mk_tick(input logic [31:0] ms, input logic rdy,
                                      input logic [1:0] phy, input logic sok,
                                      input logic rok);
        tick_t t;
        t.now_ms = ms;
        t.ready = rdy;
        t.phy = phy;
        t.soft_ok = sok;
        t.reinit_ok = rok;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one tick per call. Optional random gap, then hold valid until
    // the transfer happens; the prediction is queued at that edge.
    // ------------------------------------------------------------------
    task automatic send_tick(input tick_t t);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        now_ms        = t.now_ms;
        netif_ready   = t.ready;
        phy_status    = t.phy;
        soft_reset_ok = t.soft_ok;
        reinit_ok     = t.reinit_ok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(link_recovery_step(t));
    endtask

    // Stop sending and wait for every predicted result, plus pipeline slack.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; only called with the block drained.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ENABLE:
            begin
                // Any enable write drops the machine back to normal.
                cfg_on    = val[0];
                rec_mode  = M_NORMAL;
                phase_t0  = '0;
                down_seen = 1'b0;
            end
            REG_POLL:      cfg_poll      = val;
            REG_DOWN_DEB:  cfg_down_deb  = val;
            REG_ERR_DEB:   cfg_err_deb   = val;
            REG_SOFT_WAIT: cfg_soft_wait = val;
            REG_HARD_WAIT: cfg_hard_wait = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [15:0] poll, input logic [15:0] down_deb,
                              input logic [15:0] err_deb, input logic [15:0] soft_w,
                              input logic [15:0] hard_w);
        write_reg(REG_POLL, poll);
        write_reg(REG_DOWN_DEB, down_deb);
        write_reg(REG_ERR_DEB, err_deb);
        write_reg(REG_SOFT_WAIT, soft_w);
        write_reg(REG_HARD_WAIT, hard_w);
        write_reg(REG_ENABLE, 16'd1);
    endtask

    // Realistic traffic: a running millisecond clock, a link that drops
    // often and recovers slowly (so escalation gets deep), plus a sprinkle
    // of fully random ticks that jump the clock around.
    task automatic run_traffic(input int n, input int unsigned step_lo,
                               input int unsigned step_hi);
        tick_t t;
        logic  link_ok;
        int    pick;
        link_ok = 1'b1;
        repeat (n)
        begin
            if (link_ok ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 29) == 0))
                link_ok = ~link_ok;
            clock_ms = clock_ms + $urandom_range(step_lo, step_hi);
            pick = $urandom_range(0, 5);
            t.now_ms    = clock_ms;
            t.ready     = ($urandom_range(0, 19) != 0);
            t.phy       = link_ok ? PHY_UP :
                          (pick < 4) ? PHY_DOWN : (pick == 4) ? PHY_ERR : PHY_ODD;
            t.soft_ok   = ($urandom_range(0, 3) != 0);
            t.reinit_ok = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 24) == 0)
            begin
                t.now_ms = $urandom();
                t.ready  = 1'($urandom_range(0, 1));
                t.phy    = 2'($urandom_range(0, 3));
            end
            send_tick(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk the whole escalation ladder with hand-picked timestamps: poll
    // gate, not-ready, bounce from debounce, status three, failed soft reset,
    // failed reinit, full reinit, and restore from each wait mode.
    task automatic test_directed_escalation();
        set_timing(16'd10, 16'd100, 16'd50, 16'd200, 16'd300);
        send_tick(mk_tick(32'd0,    1'b1, PHY_UP,   1'b1, 1'b1));  // inside interval
        send_tick(mk_tick(32'd20,   1'b0, PHY_DOWN, 1'b1, 1'b1));  // interface down
        send_tick(mk_tick(32'd20,   1'b1, PHY_UP,   1'b1, 1'b1));
        send_tick(mk_tick(32'd40,   1'b1, PHY_DOWN, 1'b1, 1'b1));  // -> pending
        send_tick(mk_tick(32'd60,   1'b1, PHY_UP,   1'b1, 1'b1));  // bounce back
        send_tick(mk_tick(32'd80,   1'b1, PHY_ODD,  1'b1, 1'b1));
        send_tick(mk_tick(32'd85,   1'b1, PHY_ERR,  1'b1, 1'b1));  // gated
        send_tick(mk_tick(32'd140,  1'b1, PHY_ERR,  1'b0, 1'b1));  // soft reset fails
        send_tick(mk_tick(32'd160,  1'b1, PHY_ERR,  1'b1, 1'b1));  // -> soft wait
        send_tick(mk_tick(32'd370,  1'b1, PHY_DOWN, 1'b1, 1'b1));  // -> hard wait
        send_tick(mk_tick(32'd680,  1'b1, PHY_DOWN, 1'b1, 1'b0));  // reinit fails
        send_tick(mk_tick(32'd790,  1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd1000, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd1310, 1'b1, PHY_DOWN, 1'b1, 1'b1));  // -> full wait
        send_tick(mk_tick(32'd1400, 1'b1, PHY_UP,   1'b1, 1'b1));  // restore from full
        send_tick(mk_tick(32'd1420, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd1530, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd1600, 1'b1, PHY_UP,   1'b1, 1'b1));  // restore from soft
        send_tick(mk_tick(32'd1620, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd1730, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd1940, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd1950, 1'b1, PHY_UP,   1'b1, 1'b1));  // restore from hard
        drain();
    endtask

    // Disabled machine, timestamp wrap, and the interval gate at its limits.
    task automatic test_config_extremes();
        write_reg(REG_ENABLE, 16'd0);
        send_tick(mk_tick(32'd5000, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, PHY_ERR, 1'b1, 1'b1));
        drain();

        // Debounce across the 32-bit wrap.
        write_reg(REG_ENABLE, 16'd1);
        send_tick(mk_tick(32'hFFFF_FFF0, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'h0000_0060, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        drain();

        // Longest interval: one ms short is gated, exactly on it passes.
        write_reg(REG_POLL, 16'hFFFF);
        send_tick(mk_tick(last_eval + 32'h0000_FFFE, 1'b1, PHY_UP, 1'b1, 1'b1));
        send_tick(mk_tick(last_eval + 32'h0000_FFFF, 1'b1, PHY_UP, 1'b1, 1'b1));
        drain();

        // Zero interval: repeated timestamps are all evaluated.
        write_reg(REG_POLL, 16'd0);
        send_tick(mk_tick(32'd0, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd0, 1'b1, PHY_DOWN, 1'b1, 1'b1));
        send_tick(mk_tick(32'd0, 1'b1, PHY_UP,   1'b0, 1'b0));
        drain();
    endtask

    // Bulk of the run: several timing settings, all-zero and all-max included.
    task automatic test_random_recovery();
        for (int ph = 0; ph < 8; ph++)
        begin
            clock_ms = (ph % 2) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
            if (ph == 0)
            begin
                set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                run_traffic(250, 0, 60);
            end
            else if (ph == 1)
            begin
                set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                run_traffic(250, 30000, 140000);
            end
            else
            begin
                set_timing(16'($urandom_range(0, 30)), 16'($urandom_range(0, 200)),
                           16'($urandom_range(0, 120)), 16'($urandom_range(0, 300)),
                           16'($urandom_range(0, 300)));
                run_traffic(250, 0, 60);
            end
            drain();
        end
    endtask

    // Receiver holds off long enough to fill both stages and raise in_stall
    // while the sender keeps offering; then the sender waits for a full drain.
    task automatic test_backpressure();
        set_timing(16'd5, 16'd60, 16'd30, 16'd100, 16'd120);
        hold_req = LONG_HOLD;
        run_traffic(30, 0, 40);
        drain();
        run_traffic(20, 0, 40);
        drain();
    endtask

    // Final stretch with no idling on either side: back-to-back transfers.
    task automatic test_streaming();
        idle_on = 1'b0;
        set_timing(16'd8, 16'd80, 16'd40, 16'd150, 16'd150);
        run_traffic(200, 0, 40);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver idling: short random stall bursts, or one long hold on request.
    // ------------------------------------------------------------------
    initial
    begin : rx_idle
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker: every output transfer against the oldest prediction.
    initial
    begin : result_check
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_code", 3'(want.result_code), 3'(result_code));
                    check_field("polled", 3'(want.polled), 3'(polled));
                    check_field("link_flag_write", 3'(want.link_flag_write),
                                3'(link_flag_write));
                    check_field("soft_reset_cmd", 3'(want.soft_reset_cmd),
                                3'(soft_reset_cmd));
                    check_field("hard_reset_cmd", 3'(want.hard_reset_cmd),
                                3'(hard_reset_cmd));
                    check_field("reinit_cmd", 3'(want.reinit_cmd), 3'(reinit_cmd));
                    check_field("announce_up", 3'(want.announce_up), 3'(announce_up));
                    check_field("mode_out", want.mode_out, mode_out);
                    results_checked++;
                    polls_seen       += want.polled;
                    restores_seen    += (want.result_code == RC_RESTORED);
                    reinits_seen     += (want.result_code == RC_REINIT);
                    hard_resets_seen += want.hard_reset_cmd;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ENABLE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        now_ms        = '0;
        netif_ready   = 1'b0;
        phy_status    = PHY_DOWN;
        soft_reset_ok = 1'b0;
        reinit_ok     = 1'b0;
        idle_on       = 1'b1;
        hold_req      = 0;
        clock_ms      = '0;
        fail_count    = 0;

        // Predictor starts from the block's reset state.
        cfg_on        = 1'b0;
        cfg_poll      = POLL_RST;
        cfg_down_deb  = DOWN_DEB_RST;
        cfg_err_deb   = ERR_DEB_RST;
        cfg_soft_wait = SOFT_WAIT_RST;
        cfg_hard_wait = HARD_WAIT_RST;
        rec_mode      = M_NORMAL;
        phase_t0      = '0;
        last_eval     = '0;
        down_seen     = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_escalation();
        test_config_extremes();
        test_random_recovery();
        test_backpressure();
        test_streaming();

        drain();
        repeat (8) @(posedge clk);
        $display("Checked %0d results: %0d evaluated polls, %0d restores,", results_checked,
                 polls_seen, restores_seen);
        $display("%0d reinits and %0d hard resets, under random stalls and a long hold.",
                 reinits_seen, hard_resets_seen);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
